FILE: hw/rtl/ffua_pkg.sv
// ----------------------------------------------------------------------------
// ffua_pkg
// Shared types and constants of the first-fit unit allocator.
// ----------------------------------------------------------------------------
package ffua_pkg;

  localparam int MemUnits = 4096;
  localparam int WordW    = 16;
  localparam int WordBits = 4;
  localparam int BlockMax = 8191;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [12:0] run_size;
    logic [11:0] free_base;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] alloc_base;
    logic [12:0] used_units;
    logic [12:0] free_units;
    logic [12:0] live_blocks;
  } rsp_t;

  typedef struct packed {
    logic                found;
    logic [WordBits-1:0] pos;
  } scan_t;

endpackage

FILE: hw/rtl/ffua_ram.sv
// ----------------------------------------------------------------------------
// ffua_ram
// Bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffua_ram #(
  parameter int Depth = 256,
  parameter int AW    = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [ffua_pkg::WordW-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [ffua_pkg::WordW-1:0] rdata_o
);

  logic [ffua_pkg::WordW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/ffua_word_scan.sv
// ----------------------------------------------------------------------------
// ffua_word_scan
// Free-run search over one bitmap word, carrying the run length across words.
// ----------------------------------------------------------------------------
module ffua_word_scan #(
  parameter int CW = 13
) (
  input  logic [ffua_pkg::WordW-1:0] word_i,
  input  logic [CW-1:0]              carry_i,
  input  logic [CW-1:0]              len_i,
  output logic [CW-1:0]              carry_o,
  output ffua_pkg::scan_t            scan_o
);

  logic [CW-1:0] run [ffua_pkg::WordW];

  always_comb begin
    logic                          seen;
    logic [ffua_pkg::WordBits-1:0] lastp;
    scan_o = '0;
    for (int i = 0; i < ffua_pkg::WordW; i++) begin
      seen  = 1'b0;
      lastp = '0;
      for (int j = 0; j <= i; j++) begin
        if (word_i[j]) begin
          seen  = 1'b1;
          lastp = ffua_pkg::WordBits'(j);
        end
      end
      if (word_i[i]) begin
        run[i] = '0;
      end else if (seen) begin
        run[i] = CW'(i) - CW'(lastp);
      end else begin
        run[i] = carry_i + CW'(i + 1);
      end
    end
    for (int i = ffua_pkg::WordW - 1; i >= 0; i--) begin
      if (run[i] >= len_i) begin
        scan_o.found = 1'b1;
        scan_o.pos   = ffua_pkg::WordBits'(i);
      end
    end
    carry_o = run[ffua_pkg::WordW-1];
  end

endmodule

FILE: hw/rtl/first_fit_unit_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_unit
// First-fit run allocator over a one-bit-per-unit bitmap.
// ----------------------------------------------------------------------------
// One request at a time: start_i is taken when busy_o is low, and the result
// appears for one cycle with done_o high; the receiver cannot stall it. The
// bitmap sits in a RAM of MEM_UNITS/16 words of 16 bits, rounded up; units
// past the end of memory in the last word are kept marked used. After reset
// a clearing pass writes every word, one word a cycle, with busy_o high. An
// allocate scans words from the bottom, one word a cycle, then marks the run
// with a read and a write per word touched. A free first checks the base
// word, then clears the run with a read and a write per word touched; a
// free of size zero clears nothing. A zero-size or oversized allocate and a
// free base beyond memory go to the result without touching the bitmap; a
// free whose base unit is not used ends after the base-word check.
module first_fit_unit_allocator_unit #(
  parameter int MEM_UNITS = ffua_pkg::MemUnits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ffua_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output ffua_pkg::rsp_t rsp_o
);

  localparam int Depth = (MEM_UNITS + ffua_pkg::WordW - 1) / ffua_pkg::WordW;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int UW    = AW + ffua_pkg::WordBits;
  localparam int CW    = $clog2(MEM_UNITS + 1);
  localparam int WB    = ffua_pkg::WordBits;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_RD    = 7'b0010000,
    S_WR    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [AW:0]              iss_q, iss_d;
  logic                     rvalid_q, rvalid_d;
  logic [AW-1:0]            rword_q, rword_d;
  logic [CW-1:0]            carry_q, carry_d;
  logic [CW-1:0]            len_q, len_d;
  logic [UW-1:0]            fbase_q, fbase_d;
  logic                     set_q, set_d;
  logic [CW-1:0]            lo_q, lo_d;
  logic [CW-1:0]            hi_q, hi_d;
  logic [AW-1:0]            cur_q, cur_d;
  logic [CW-1:0]            used_q, used_d;
  logic [12:0]              blk_q, blk_d;
  ffua_pkg::status_e        status_q, status_d;
  logic [UW-1:0]            base_q, base_d;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ffua_pkg::WordW-1:0] wdata;
  logic [AW-1:0]            raddr;
  logic [ffua_pkg::WordW-1:0] rdata;
  logic [CW-1:0]            carry_nx;
  ffua_pkg::scan_t          scan;
  logic [ffua_pkg::WordW-1:0] mask;
  logic [ffua_pkg::WordW-1:0] pad;
  logic [UW-1:0]            last_unit;
  logic [UW-1:0]            found_base;

  ffua_ram #(.Depth(Depth), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ffua_word_scan #(.CW(CW)) u_scan (
    .word_i  (rdata),
    .carry_i (carry_q),
    .len_i   (len_q),
    .carry_o (carry_nx),
    .scan_o  (scan)
  );

  assign last_unit  = UW'(hi_q - CW'(1));
  assign found_base = UW'({rword_q, scan.pos}) + UW'(1) - UW'(len_q);

  always_comb begin
    for (int b = 0; b < ffua_pkg::WordW; b++) begin
      mask[b] = (CW'({cur_q, WB'(b)}) >= lo_q) && (CW'({cur_q, WB'(b)}) < hi_q);
    end
  end

  // units past the end of memory never take part in a run
  always_comb begin
    for (int b = 0; b < ffua_pkg::WordW; b++) begin
      pad[b] = (32'({clr_q, WB'(b)}) >= MEM_UNITS);
    end
  end

  always_comb begin
    int hi_sum;
    state_d  = state_q;
    clr_d    = clr_q;
    iss_d    = iss_q;
    rvalid_d = 1'b0;
    rword_d  = rword_q;
    carry_d  = carry_q;
    len_d    = len_q;
    fbase_d  = fbase_q;
    set_d    = set_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cur_d    = cur_q;
    used_d   = used_q;
    blk_d    = blk_q;
    status_d = status_q;
    base_d   = base_q;
    we       = 1'b0;
    waddr    = cur_q;
    wdata    = '0;
    raddr    = cur_q;
    hi_sum   = 0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = pad;
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == Depth - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          status_d = ffua_pkg::ST_OK;
          base_d   = '0;
          if (req_i.req_type == ffua_pkg::REQ_ALLOC) begin
            set_d = 1'b1;
            if (req_i.run_size == '0 || 32'(req_i.run_size) > MEM_UNITS) begin
              status_d = ffua_pkg::ST_NO_FIT;
              state_d  = S_DONE;
            end else begin
              len_d   = CW'(req_i.run_size);
              iss_d   = '0;
              carry_d = '0;
              state_d = S_SCAN;
            end
          end else begin
            set_d = 1'b0;
            if (32'(req_i.free_base) >= MEM_UNITS) begin
              status_d = ffua_pkg::ST_NOT_ALLOC;
              state_d  = S_DONE;
            end else begin
              fbase_d = UW'(req_i.free_base);
              len_d   = CW'(req_i.run_size);
              raddr   = AW'(req_i.free_base >> WB);
              hi_sum  = 32'(req_i.free_base) + 32'(req_i.run_size);
              if (hi_sum > MEM_UNITS) begin
                hi_sum = MEM_UNITS;
              end
              lo_d    = CW'(req_i.free_base);
              hi_d    = CW'(hi_sum);
              cur_d   = AW'(req_i.free_base >> WB);
              state_d = S_CHECK;
            end
          end
        end
      end
      S_SCAN: begin
        if (32'(iss_q) < Depth) begin
          raddr    = iss_q[AW-1:0];
          rvalid_d = 1'b1;
          rword_d  = iss_q[AW-1:0];
          iss_d    = iss_q + (AW+1)'(1);
        end
        if (rvalid_q) begin
          carry_d = carry_nx;
          if (scan.found) begin
            rvalid_d = 1'b0;
            base_d   = found_base;
            lo_d     = CW'(found_base);
            hi_d     = CW'(found_base) + len_q;
            cur_d    = found_base[UW-1:WB];
            used_d   = used_q + len_q;
            if (32'(blk_q) < ffua_pkg::BlockMax) begin
              blk_d = blk_q + 13'd1;
            end
            state_d = S_RD;
          end else if (32'(rword_q) == Depth - 1) begin
            rvalid_d = 1'b0;
            status_d = ffua_pkg::ST_NO_FIT;
            state_d  = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (!rdata[fbase_q[WB-1:0]]) begin
          status_d = ffua_pkg::ST_NOT_ALLOC;
          state_d  = S_DONE;
        end else begin
          if (blk_q != '0) begin
            blk_d = blk_q - 13'd1;
          end
          if (hi_q == lo_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        we = 1'b1;
        if (set_q) begin
          wdata = rdata | mask;
        end else begin
          wdata  = rdata & ~mask;
          used_d = used_q - CW'($countones(rdata & mask));
        end
        if (cur_q == last_unit[UW-1:WB]) begin
          state_d = S_DONE;
        end else begin
          cur_d   = cur_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      iss_q    <= '0;
      rvalid_q <= 1'b0;
      used_q   <= '0;
      blk_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      iss_q    <= iss_d;
      rvalid_q <= rvalid_d;
      used_q   <= used_d;
      blk_q    <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rword_q  <= rword_d;
    carry_q  <= carry_d;
    len_q    <= len_d;
    fbase_q  <= fbase_d;
    set_q    <= set_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    base_q   <= base_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign rsp_o.status      = status_q;
  assign rsp_o.alloc_base  = 12'(base_q);
  assign rsp_o.used_units  = 13'(used_q);
  assign rsp_o.free_units  = 13'(MEM_UNITS - 32'(used_q));
  assign rsp_o.live_blocks = blk_q;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result beat while not busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted request did not raise busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= MEM_UNITS) else $error("used count exceeds memory size");
`endif

endmodule
